// ===== rtl/ipt_pkg.sv =====
// Shared types and constants for the inverted page table with FIFO replacement.
// Used by ipt_cell and by the top level inverted_page_table_fifo.
// No dependencies.
package ipt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int PID_W   = 16;
    localparam int TICK_W  = 48;
    localparam int WANT_W  = 4;
    localparam int SLOT_W  = 4;
    localparam int ADDR_W  = 20;
    localparam int FS_W    = 17;
    localparam int PAGES_W = 5;
    // Slot indexes stay below the slots in use, which the pages register bounds.
    localparam int IDX_W   = PAGES_W;

    localparam logic [FS_W-1:0]    FRAME_SIZE_RST = FS_W'(4096);
    localparam logic [FS_W-1:0]    FRAME_MAX      = FS_W'(65536);
    localparam logic [PAGES_W-1:0] PAGES_RST      = PAGES_W'(16);

    typedef enum logic {
        CFG_FRAME_SIZE = 1'b0,
        CFG_PAGES      = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_TRANSLATE = 1'b0,
        OP_INSERT    = 1'b1
    } t_op;

    typedef struct packed {
        logic              op;
        logic [PID_W-1:0]  pid;
        logic [TICK_W-1:0] time_tick;
        logic              slot_given;
        logic [WANT_W-1:0] slot_wanted;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] phys_address;
        logic              was_hit;
    } t_out;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic              valid;
        logic              op;
        logic [PID_W-1:0]  pid;
        logic [TICK_W-1:0] tick;
        logic              given;
        logic [WANT_W-1:0] wanted;
        logic              found;
        logic [IDX_W-1:0]  hit_slot;
        logic              free_found;
        logic [IDX_W-1:0]  free_slot;
        logic              old_found;
        logic [IDX_W-1:0]  old_slot;
        logic [TICK_W-1:0] old_time;
        logic              want_occ;
    } t_scan;

    // Entry load broadcast to all cells.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  slot;
        logic [PID_W-1:0]  pid;
        logic [TICK_W-1:0] tick;
    } t_wr;

endpackage

// ===== rtl/ipt_cell.sv =====
// One table entry of the inverted page table plus its stage of the search chain.
// Depends on ipt_pkg for the token and load types.
module ipt_cell #(
    parameter int K = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [ipt_pkg::IDX_W-1:0] i_n,
    input  ipt_pkg::t_scan        i_tok,
    input  ipt_pkg::t_wr          i_wr,
    output ipt_pkg::t_scan        o_tok
);
    import ipt_pkg::*;

    logic [PID_W-1:0]  r_pid;
    logic [TICK_W-1:0] r_time;
    t_scan             r_tok;
    t_scan             n_tok;

    always_comb begin
        logic act;
        logic occ;
        act   = (K < 32'(i_n));
        occ   = (r_time != '0);
        n_tok = i_tok;
        if (act && occ && (r_pid == i_tok.pid)) begin
            n_tok.found    = 1'b1;
            n_tok.hit_slot = IDX_W'(K);
        end
        if (act && !occ && !i_tok.free_found) begin
            n_tok.free_found = 1'b1;
            n_tok.free_slot  = IDX_W'(K);
        end
        if (act && occ && (!i_tok.old_found || (r_time < i_tok.old_time))) begin
            n_tok.old_found = 1'b1;
            n_tok.old_slot  = IDX_W'(K);
            n_tok.old_time  = r_time;
        end
        if (32'(i_tok.wanted) == K) begin
            n_tok.want_occ = occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid  <= '0;
            r_time <= '0;
        end else if (i_wr.en && (32'(i_wr.slot) == K)) begin
            r_pid  <= i_wr.pid;
            r_time <= i_wr.tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/inverted_page_table_fifo.sv =====
// Inverted page table with FIFO replacement, built as a chain of entry cells.
// Requests are handled one at a time: a new one is taken only after the last
// result has entered the output register. The search token walks one cell per
// cycle, then the block decides and loads, multiplies, and hands the result on.
// Reset (synchronous, active low) frees every entry, sets frame_size to 4096
// and pages_in_use to 16, and empties the output register.
module inverted_page_table_fifo #(
    parameter int TABLE_ENTRIES = ipt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  ipt_pkg::t_in               i_data,
    output logic                       o_stall,
    output logic                       o_valid,
    output ipt_pkg::t_out              o_data,
    input  logic                       i_stall,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [ipt_pkg::FS_W-1:0]   i_cfg_data
);
    import ipt_pkg::*;

    // One-hot sequencer: wait for a transfer, let the token walk the chain,
    // form the address product, then hand the result to the output register.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [FS_W-1:0]    r_frame;
    logic [PAGES_W-1:0] r_pages;

    logic [IDX_W-1:0]   r_slot;
    logic               r_hit;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_out_valid;
    t_out               r_out;

    logic [IDX_W-1:0]   w_n;
    logic [FS_W-1:0]    w_fs;
    logic               w_accept;
    t_scan              w_head;
    t_scan              w_scan [0:TABLE_ENTRIES];
    t_scan              w_last;
    t_wr                w_wr;
    logic [IDX_W-1:0]   w_sel;
    logic               w_sel_hit;
    logic               w_load_out;
    logic [IDX_W+FS_W-1:0] w_prod;

    // Slots in use: zero counts as one, anything above the table size is clipped.
    always_comb begin
        if (r_pages == '0) begin
            w_n = IDX_W'(1);
        end else if (32'(r_pages) > TABLE_ENTRIES) begin
            w_n = IDX_W'(TABLE_ENTRIES);
        end else begin
            w_n = r_pages;
        end
    end

    assign w_fs = (r_frame > FRAME_MAX) ? FRAME_MAX : r_frame;

    // The user must write the configuration registers only while the block is idle; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= FRAME_SIZE_RST;
            r_pages <= PAGES_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_SIZE: r_frame <= i_cfg_data;
                CFG_PAGES:      r_pages <= PAGES_W'(i_cfg_data);
                default:        r_frame <= r_frame;
            endcase
        end
    end

    // A transfer is taken only when the sequencer is idle; a result still
    // waiting in the output register does not hold it back.
    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;

    // Fresh token with empty search results enters the first cell.
    always_comb begin
        w_head            = '0;
        w_head.valid      = w_accept;
        w_head.op         = i_data.op;
        w_head.pid        = i_data.pid;
        w_head.tick       = i_data.time_tick;
        w_head.given      = i_data.slot_given;
        w_head.wanted     = i_data.slot_wanted;
    end

    assign w_scan[0] = w_head;

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        ipt_cell #(
            .K (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_n     (w_n),
            .i_tok   (w_scan[k]),
            .i_wr    (w_wr),
            .o_tok   (w_scan[k+1])
        );
    end

    assign w_last = w_scan[TABLE_ENTRIES];

    // Once the token leaves the last cell it carries the last matching slot,
    // the first free slot and the oldest occupied slot. A translate hit loads
    // nothing. A miss, or an insert without a usable wanted slot, takes the
    // first free slot and otherwise the oldest. An insert at an occupied
    // wanted slot replaces the oldest entry even if free slots exist.
    always_comb begin
        logic choose_free;
        choose_free = 1'b1;
        w_sel_hit   = 1'b0;
        w_sel       = w_last.free_found ? w_last.free_slot : w_last.old_slot;
        if (t_op'(w_last.op) == OP_TRANSLATE) begin
            if (w_last.found) begin
                w_sel_hit = 1'b1;
                w_sel     = w_last.hit_slot;
            end
        end else if (w_last.given && (32'(w_last.wanted) < 32'(w_n))) begin
            choose_free = 1'b0;
            w_sel       = w_last.want_occ ? w_last.old_slot : IDX_W'(w_last.wanted);
        end
        w_wr.en   = (r_state == ST_SCAN) && w_last.valid && !w_sel_hit && choose_free
                    || (r_state == ST_SCAN) && w_last.valid && !choose_free;
        w_wr.slot = w_sel;
        w_wr.pid  = w_last.pid;
        w_wr.tick = w_last.tick;
    end

    assign w_prod = {{FS_W{1'b0}}, r_slot} * {{IDX_W{1'b0}}, w_fs};

    assign w_load_out = (r_state == ST_FIN) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_SCAN;
            ST_SCAN: if (w_last.valid) n_state = ST_MUL;
            ST_MUL:  n_state = ST_FIN;
            ST_FIN:  if (w_load_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SCAN) && w_last.valid) begin
            r_slot <= w_sel;
            r_hit  <= w_sel_hit;
        end
        if (r_state == ST_MUL) begin
            r_addr <= ADDR_W'(w_prod);
        end
        if (w_load_out) begin
            r_out.slot         <= SLOT_W'(r_slot);
            r_out.phys_address <= r_addr;
            r_out.was_hit      <= r_hit;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== verif/inverted_page_table_fifo_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the inverted page table with FIFO replacement.
// Depends on ipt_pkg and inverted_page_table_fifo; it carries its own model of
// the table, drives random traffic with gaps and stalls, and checks every result.
module inverted_page_table_fifo_test;
    import ipt_pkg::*;

    localparam int TABLE           = TABLE_ENTRIES_DEF;
    localparam int LATENCY         = TABLE + 2;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int POOL            = 24;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 400000;

    // The tracker mirrors the table contents and the two registers. Each accepted
    // request is applied to the mirror at once, and the frame it must produce is
    // queued; results from the block are matched against that queue in order.
    class page_table_tracker;
        logic [PID_W-1:0]   owner_pid [TABLE];
        logic [TICK_W-1:0]  load_tick [TABLE];
        logic [FS_W-1:0]    frame_bytes;
        logic [PAGES_W-1:0] pages_reg;
        t_out               pending_frames [$];
        int                 error_count;
        int                 checked_count;
        int                 hit_count;
        int                 insert_count;

        function new();
            for (int i = 0; i < TABLE; i++) begin
                owner_pid[i] = '0;
                load_tick[i] = '0;
            end
            frame_bytes   = FRAME_SIZE_RST;
            pages_reg     = PAGES_RST;
            error_count   = 0;
            checked_count = 0;
            hit_count     = 0;
            insert_count  = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [FS_W-1:0] value);
            if (idx == CFG_FRAME_SIZE) begin
                frame_bytes = value;
            end else begin
                pages_reg = value[PAGES_W-1:0];
            end
        endfunction

        // Occupied slot with the smallest load time, the first one on a tie.
        function int unsigned oldest_loaded(int unsigned n);
            int unsigned       best;
            logic [TICK_W-1:0] best_tick;
            best      = n;
            best_tick = '0;
            for (int i = 0; i < n; i++) begin
                if (load_tick[i] != '0 && (best == n || load_tick[i] < best_tick)) begin
                    best      = i;
                    best_tick = load_tick[i];
                end
            end
            return best;
        endfunction

        function int unsigned pick_slot(int unsigned n);
            for (int i = 0; i < n; i++) begin
                if (load_tick[i] == '0) return i;
            end
            return oldest_loaded(n);
        endfunction

        function void note_request(t_in req);
            t_out        res;
            int unsigned n;
            int unsigned s;
            int unsigned fs;
            bit          found;
            n     = (pages_reg == 0) ? 1 : (pages_reg > TABLE) ? TABLE : pages_reg;
            s     = 0;
            found = 1'b0;
            if (req.op == OP_TRANSLATE) begin
                // Free slots are skipped even when their pid matches; last match wins.
                for (int i = 0; i < n; i++) begin
                    if (load_tick[i] != '0 && owner_pid[i] == req.pid) begin
                        s     = i;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    hit_count++;
                end else begin
                    s = pick_slot(n);
                end
            end else begin
                insert_count++;
                // A named slot that is occupied sends the load to the oldest entry,
                // even with other slots free; a slot outside the range is ignored.
                if (req.slot_given && req.slot_wanted < n) begin
                    s = (load_tick[req.slot_wanted] == '0) ? req.slot_wanted
                                                           : oldest_loaded(n);
                end else begin
                    s = pick_slot(n);
                end
            end
            // A load with tick zero leaves the slot marked free.
            if (!found && s < TABLE) begin
                owner_pid[s] = req.pid;
                load_tick[s] = req.time_tick;
            end
            if (s >= n) s = 0;
            fs = (frame_bytes > FRAME_MAX) ? FRAME_MAX : frame_bytes;
            res.slot         = s[SLOT_W-1:0];
            res.phys_address = ADDR_W'(s * fs);
            res.was_hit      = found;
            pending_frames.push_back(res);
        endfunction

        function void check_result(t_out got);
            t_out want;
            checked_count++;
            if (pending_frames.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("[%0t] result with nothing expected: slot %0d addr 0x%05h hit %0b",
                             $time, got.slot, got.phys_address, got.was_hit);
                end
                return;
            end
            want = pending_frames.pop_front();
            if (got.slot !== want.slot || got.phys_address !== want.phys_address ||
                got.was_hit !== want.was_hit) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("[%0t] mismatch: expected slot %0d addr 0x%05h hit %0b, got slot %0d addr 0x%05h hit %0b",
                             $time, want.slot, want.phys_address, want.was_hit,
                             got.slot, got.phys_address, got.was_hit);
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    t_in               i_data;
    logic              o_stall;
    logic              o_valid;
    t_out              o_data;
    logic              i_stall;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [FS_W-1:0]   i_cfg_data;

    page_table_tracker tracker;
    logic [PID_W-1:0]  pid_pool [POOL];
    logic [TICK_W-1:0] tick_now;
    bit                calm          = 1'b0;
    int                hold_requests = 0;
    int                holds_done    = 0;
    int                hold_left     = 0;
    int                settings_seen = 0;
    int                cycle_count   = 0;

    inverted_page_table_fifo dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, tracker.pending_frames.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side. Signals are sampled right after the edge, so they hold the
    // values the block saw at that edge. A hold-off request from the stimulus
    // process makes this side stall for a long stretch, counted here, so that
    // the output register fills and the block pushes back on its input.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) tracker.check_result(o_data);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_requests > holds_done) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < 20);
            end
        end
    end

    function automatic t_in make_item(t_op op, logic [PID_W-1:0] pid,
                                      logic [TICK_W-1:0] tick, logic given,
                                      logic [WANT_W-1:0] wanted);
        t_in r;
        r.op          = op;
        r.pid         = pid;
        r.time_tick   = tick;
        r.slot_given  = given;
        r.slot_wanted = wanted;
        return r;
    endfunction

    // Mostly pids from a small pool so that hits and FIFO replacement happen
    // often, with a steadily rising tick; now and then a fresh pid, a tick from
    // anywhere in the 48-bit range, or a tick of zero.
    function automatic t_in random_request();
        t_in         r;
        int unsigned roll;
        r.op  = ($urandom_range(99) < 70) ? OP_TRANSLATE : OP_INSERT;
        r.pid = ($urandom_range(99) < 75) ? pid_pool[$urandom_range(POOL-1)]
                                          : PID_W'($urandom);
        tick_now = tick_now + TICK_W'($urandom_range(1, 3));
        roll = $urandom_range(31);
        if (roll == 0) begin
            r.time_tick = '0;
        end else if (roll < 3) begin
            r.time_tick = {16'($urandom), 32'($urandom)};
        end else begin
            r.time_tick = tick_now;
        end
        r.slot_given  = 1'($urandom);
        r.slot_wanted = WANT_W'($urandom);
        return r;
    endfunction

    // Offers one request and returns at the edge where it transfers. Valid is
    // left high, so back-to-back requests need only one assignment per step.
    task automatic send_request(input t_in req);
        while (!calm && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (o_stall);
        tracker.note_request(req);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (tracker.pending_frames.size() != 0) @(posedge i_clk);
    endtask

    // Writes the frame size register and then the pages register; the block is idle here.
    // Bits above the pages field are random, since the register keeps only five.
    task automatic write_registers(input logic [FS_W-1:0] frame,
                                   input logic [PAGES_W-1:0] pages);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FRAME_SIZE;
        i_cfg_data <= frame;
        @(posedge i_clk);
        tracker.set_register(CFG_FRAME_SIZE, frame);
        i_cfg_idx  <= CFG_PAGES;
        i_cfg_data <= {12'($urandom), pages};
        @(posedge i_clk);
        tracker.set_register(CFG_PAGES, {12'd0, pages});
        i_cfg_we   <= 1'b0;
        settings_seen++;
    endtask

    initial begin
        logic [FS_W-1:0]    frame_val;
        logic [PAGES_W-1:0] pages_val;
        tracker = new();
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_data     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_FRAME_SIZE;
        i_cfg_data <= '0;
        pid_pool[0] = '0;
        pid_pool[1] = '1;
        for (int i = 2; i < POOL; i++) pid_pool[i] = PID_W'($urandom);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, starting from the reset settings of 16 slots and 4 KiB.
        // A load at tick zero leaves slot 0 free, so the same pid misses again.
        send_request(make_item(OP_TRANSLATE, 16'h0000, 48'd0, 1'b0, 4'd0));
        send_request(make_item(OP_TRANSLATE, 16'h0000, 48'd5, 1'b0, 4'd0));
        send_request(make_item(OP_TRANSLATE, 16'h0000, 48'd6, 1'b0, 4'd0));
        send_request(make_item(OP_TRANSLATE, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 4'hF));
        // Insert into a named free slot, then into a named occupied one, which
        // replaces the oldest entry instead.
        send_request(make_item(OP_INSERT, 16'h1234, 48'd7, 1'b1, 4'hF));
        send_request(make_item(OP_INSERT, 16'h4321, 48'd8, 1'b1, 4'h0));
        send_request(make_item(OP_INSERT, 16'hABCD, 48'd9, 1'b0, 4'h5));
        // A duplicate pid: the later slot wins on the following lookup.
        send_request(make_item(OP_INSERT, 16'hFFFF, 48'd10, 1'b0, 4'h0));
        send_request(make_item(OP_TRANSLATE, 16'hFFFF, 48'd11, 1'b0, 4'h0));
        send_request(make_item(OP_TRANSLATE, 16'h0000, 48'd12, 1'b0, 4'h0));

        // Both registers above their ranges: clamped to 16 slots and 64 KiB.
        wait_drained();
        write_registers(17'd65537, 5'd31);
        send_request(make_item(OP_TRANSLATE, 16'hABCD, 48'd20, 1'b0, 4'h0));
        send_request(make_item(OP_TRANSLATE, 16'h5555, 48'd21, 1'b0, 4'h0));

        // Zero frame size and zero slots (counts as one); a wanted slot outside
        // the range is treated as no slot at all.
        wait_drained();
        write_registers(17'd0, 5'd0);
        send_request(make_item(OP_INSERT, 16'h0007, 48'd1, 1'b1, 4'h3));
        send_request(make_item(OP_TRANSLATE, 16'h0007, 48'd22, 1'b0, 4'h0));

        // Largest register value and three slots: an insert at tick zero frees
        // the oldest slot, which the next miss then takes.
        wait_drained();
        write_registers(17'h1FFFF, 5'd3);
        send_request(make_item(OP_TRANSLATE, 16'hFFFF, 48'd23, 1'b0, 4'h0));
        send_request(make_item(OP_INSERT, 16'h8000, 48'd0, 1'b1, 4'h2));
        send_request(make_item(OP_TRANSLATE, 16'h0007, 48'd30, 1'b0, 4'h0));
        send_request(make_item(OP_TRANSLATE, 16'h0F0F, 48'd40, 1'b0, 4'h0));
        send_request(make_item(OP_INSERT, 16'h00F0, 48'd41, 1'b1, 4'h1));

        // Random phases, each under its own register setting. Phase one runs
        // without any idling; phase two starts with the long result hold-off.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       begin frame_val = 17'd4096;  pages_val = 5'd16; end
                1:       begin frame_val = 17'd65536; pages_val = 5'd1;  end
                2:       begin frame_val = 17'd1;     pages_val = 5'd17; end
                3:       begin frame_val = 17'h1FFFF; pages_val = 5'd4;  end
                4:       begin frame_val = 17'd0;     pages_val = 5'd0;  end
                5:       begin frame_val = 17'd65537; pages_val = 5'd31; end
                default: begin
                    frame_val = FS_W'($urandom);
                    pages_val = PAGES_W'($urandom_range(1, TABLE));
                end
            endcase
            wait_drained();
            write_registers(frame_val, pages_val);
            calm = (ph == 1);
            if (ph == 2) hold_requests++;
            tick_now = {16'($urandom_range(255)), 32'($urandom)};
            for (int k = 0; k < ITEMS_PER_PHASE; k++) send_request(random_request());
        end

        wait_drained();
        repeat (LATENCY + 8) @(posedge i_clk);
        $display("Checked %0d results over %0d register settings: %0d translate hits, %0d inserts.",
                 tracker.checked_count, settings_seen, tracker.hit_count,
                 tracker.insert_count);
        $display("Errors: %0d, results still outstanding: %0d.",
                 tracker.error_count, tracker.pending_frames.size());
        if (tracker.error_count == 0 && tracker.pending_frames.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
